// ===== sv/mqttfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqttfr_pkg
// Types and constants for the publish / subscribe packet framer.
// ----------------------------------------------------------------------------
package mqttfr_pkg;

   // packet in progress
   typedef enum logic [1:0] {
      KIND_IDLE = 2'd0,
      KIND_PUB  = 2'd1,
      KIND_SUB  = 2'd2
   } kind_type;

   // request action codes
   localparam logic [1:0] ACT_START_PUB = 2'd0;
   localparam logic [1:0] ACT_START_SUB = 2'd1;
   localparam logic [1:0] ACT_BYTE      = 2'd2;

   // fixed header bytes
   localparam logic [7:0] HDR_PUBLISH   = 8'h30;
   localparam logic [7:0] HDR_SUBSCRIBE = 8'h82;
   localparam logic [7:0] SUB_LEN_EXTRA = 8'd5;

   // result buffer sizing
   localparam int MAX_RESULTS = 8;
   localparam int IDX_W       = $clog2(MAX_RESULTS);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef logic [7:0] byte_type;
   typedef byte_type [MAX_RESULTS-1:0] burst_type;

endpackage
`default_nettype wire

// ===== sv/mqtt_publish_subscribe_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqtt_publish_subscribe_framer
// Builds publish and subscribe packets as a byte stream from start and
// payload requests.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser  | tlast
//  req_    | in  | topic_length, data_length, qos, in_byte | action | -
//  rsp_    | out | out_byte                                | -      | packet_end
//
//  a request sits in the input register, is framed in one pass and its bytes
//  go to an eight-entry result buffer that drains one byte per cycle while
//  rsp_tready holds. payload requests stream at one per cycle when the output
//  does not stall; a start request puts four to eight bytes in the buffer.
//  the next request is accepted while the last byte of the buffer goes out.
//  reset is synchronous and clears the packet state and both valid paths.
// ----------------------------------------------------------------------------
module mqtt_publish_subscribe_framer
   import mqttfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // topic_length, data_length, qos, in_byte, zero pad
   input  wire logic [1:0]  req_tuser,  // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // out_byte
   output logic             rsp_tlast   // packet_end
);

   // input register
   logic              in_valid_ff;
   logic [1:0]        act_ff;
   logic [15:0]       tl_ff;
   logic [15:0]       dl_ff;
   logic [1:0]        q_ff;
   logic [7:0]        b_ff;

   // packet state
   kind_type          kind_ff, kind_in;
   logic [1:0]        qos_ff, qos_in;
   logic [15:0]       topic_left_ff, topic_left_in;
   logic [15:0]       data_left_ff, data_left_in;
   logic [15:0]       packet_id_ff, packet_id_in;

   // result buffer
   burst_type         buf_ff, buf_in;
   logic [CNT_W-1:0]  left_ff, cnt_in;
   logic [IDX_W-1:0]  rd_ff;
   logic              end_ff, end_in;

   logic              load;
   logic              req_fire;
   logic              rsp_fire;
   logic [15:0]       rem_len;
   logic [15:0]       topic_dec;
   logic [15:0]       data_dec;

   assign req_fire  = req_tvalid & req_tready;
   assign rsp_fire  = rsp_tvalid & rsp_tready;
   assign load      = in_valid_ff &
                      ((left_ff == '0) || ((left_ff == CNT_W'(1)) && rsp_tready));
   assign req_tready = ~in_valid_ff | load;

   assign rsp_tvalid = (left_ff != '0);
   assign rsp_tdata  = buf_ff[rd_ff];
   assign rsp_tlast  = end_ff & (left_ff == CNT_W'(1));

   assign rem_len   = 16'(17'd2 + {1'b0, tl_ff} + {1'b0, dl_ff} +
                          ((q_ff != 2'd0) ? 17'd2 : 17'd0));
   assign topic_dec = topic_left_ff - 16'd1;
   assign data_dec  = data_left_ff - 16'd1;

   always_comb begin
      logic [CNT_W-1:0] n;
      logic             topic_done;
      logic             finish;
      kind_in       = kind_ff;
      qos_in        = qos_ff;
      topic_left_in = topic_left_ff;
      data_left_in  = data_left_ff;
      packet_id_in  = packet_id_ff;
      buf_in        = '0;
      n             = '0;
      topic_done    = 1'b0;
      finish        = 1'b0;
      if (load) begin
         case (act_ff)
            ACT_START_PUB: begin
               kind_in       = KIND_PUB;
               qos_in        = q_ff;
               topic_left_in = tl_ff;
               data_left_in  = dl_ff;
               buf_in[0]     = HDR_PUBLISH | {5'd0, q_ff, 1'b0};
               buf_in[1]     = {(rem_len[15:7] != 9'd0), rem_len[6:0]};
               n             = CNT_W'(2);
               if (rem_len[15:7] != 9'd0) begin
                  buf_in[n[IDX_W-1:0]] = {(rem_len[15:14] != 2'd0), rem_len[13:7]};
                  n = n + CNT_W'(1);
               end
               if (rem_len[15:14] != 2'd0) begin
                  buf_in[n[IDX_W-1:0]] = {6'd0, rem_len[15:14]};
                  n = n + CNT_W'(1);
               end
               buf_in[n[IDX_W-1:0]] = tl_ff[15:8];
               n = n + CNT_W'(1);
               buf_in[n[IDX_W-1:0]] = tl_ff[7:0];
               n = n + CNT_W'(1);
               topic_done = (tl_ff == 16'd0);
            end
            ACT_START_SUB: begin
               kind_in       = KIND_SUB;
               qos_in        = q_ff;
               topic_left_in = tl_ff;
               data_left_in  = 16'd0;
               buf_in[0]     = HDR_SUBSCRIBE;
               buf_in[1]     = tl_ff[7:0] + SUB_LEN_EXTRA;
               buf_in[2]     = packet_id_ff[15:8];
               buf_in[3]     = packet_id_ff[7:0];
               buf_in[4]     = tl_ff[15:8];
               buf_in[5]     = tl_ff[7:0];
               n             = CNT_W'(6);
               packet_id_in  = packet_id_ff + 16'd1;
               topic_done    = (tl_ff == 16'd0);
            end
            ACT_BYTE: begin
               if (kind_ff != KIND_IDLE) begin
                  if (topic_left_ff != 16'd0) begin
                     buf_in[0]     = b_ff;
                     n             = CNT_W'(1);
                     topic_left_in = topic_dec;
                     topic_done    = (topic_dec == 16'd0);
                  end else if ((kind_ff == KIND_PUB) && (data_left_ff != 16'd0)) begin
                     buf_in[0]    = b_ff;
                     n            = CNT_W'(1);
                     data_left_in = data_dec;
                     finish       = (data_dec == 16'd0);
                  end else begin
                     kind_in = KIND_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
         // tail once the topic has gone through
         if (topic_done) begin
            if (kind_in == KIND_PUB) begin
               if (qos_in != 2'd0) begin
                  buf_in[n[IDX_W-1:0]] = packet_id_ff[15:8];
                  n = n + CNT_W'(1);
                  buf_in[n[IDX_W-1:0]] = packet_id_ff[7:0];
                  n = n + CNT_W'(1);
                  packet_id_in = packet_id_ff + 16'd1;
               end
               finish = (data_left_in == 16'd0);
            end else begin
               buf_in[n[IDX_W-1:0]] = {6'd0, qos_in};
               n = n + CNT_W'(1);
               finish = 1'b1;
            end
         end
         if (finish) begin
            kind_in = KIND_IDLE;
         end
      end
      cnt_in = n;
      end_in = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (load) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= req_tuser;
         tl_ff  <= req_tdata[15:0];
         dl_ff  <= req_tdata[31:16];
         q_ff   <= req_tdata[33:32];
         b_ff   <= req_tdata[41:34];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= KIND_IDLE;
         qos_ff        <= 2'd0;
         topic_left_ff <= 16'd0;
         data_left_ff  <= 16'd0;
         packet_id_ff  <= 16'd0;
      end else begin
         kind_ff       <= kind_in;
         qos_ff        <= qos_in;
         topic_left_ff <= topic_left_in;
         data_left_ff  <= data_left_in;
         packet_id_ff  <= packet_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         rd_ff   <= '0;
      end else if (load) begin
         left_ff <= cnt_in;
         rd_ff   <= '0;
      end else if (rsp_fire) begin
         left_ff <= left_ff - CNT_W'(1);
         rd_ff   <= rd_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= buf_in;
         end_ff <= end_in;
      end
   end

`ifndef ASSERT_OFF
   // a subscribe still open always has topic bytes to come
   a_sub_open: assert property (@(posedge clock) disable iff (reset)
      (kind_ff == KIND_SUB) |-> (topic_left_ff != 16'd0))
      else $error("subscribe open with no topic bytes left");

   // a publish still open always has topic or data bytes to come
   a_pub_open: assert property (@(posedge clock) disable iff (reset)
      (kind_ff == KIND_PUB) |-> ((topic_left_ff != 16'd0) || (data_left_ff != 16'd0)))
      else $error("publish open with nothing left");

   // the read pointer never runs past the end of the result buffer
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W + 1)'(rd_ff) + (CNT_W + 1)'(left_ff)) <= (CNT_W + 1)'(MAX_RESULTS))
      else $error("result buffer overrun");

   // packet id moves by at most one per request
   a_id_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> ((packet_id_ff == $past(packet_id_ff)) ||
                         (packet_id_ff == $past(packet_id_ff) + 16'd1)))
      else $error("packet id jumped");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_mqtt_publish_subscribe_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mqtt_publish_subscribe_framer
// Drives start and payload requests into the framer with random gaps, keeps
// its own model of the packet state to predict every byte of the outgoing
// stream, and checks each byte and its end-of-packet flag in order, under
// random backpressure on the output.
// ----------------------------------------------------------------------------
module tb_mqtt_publish_subscribe_framer;
   import mqttfr_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 5;
   localparam int RANDOM_ITEMS = 230;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 32;
   localparam int IDLE_PCT     = 18;
   localparam int QUIET_FROM   = 250;
   localparam int QUIET_TO     = 650;
   localparam int MAX_REPORTS  = 10;

   // the one action code the block has no use for
   localparam logic [1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] topic_len;
      logic [15:0] data_len;
      logic [1:0]  qos;
      logic [7:0]  in_byte;
   } request_t;

   typedef struct packed {
      byte_type value;
      logic     last;
   } packet_byte_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // topic_length, data_length, qos, in_byte, zero pad
   logic [1:0]  req_tuser  = ACT_NONE;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;   // out_byte
   logic        rsp_tlast;   // packet_end

   request_t     pending_requests[$];
   request_t     drive_req;
   packet_byte_t packet_bytes_due[$];
   packet_byte_t due_byte;
   int           cycle_count = 0;
   int           failures    = 0;
   logic         quiet;

   // framer state as the testbench sees it
   kind_type    frame_kind      = KIND_IDLE;
   logic [1:0]  frame_qos       = 2'd0;
   logic [15:0] topic_remaining = 16'd0;
   logic [15:0] data_remaining  = 16'd0;
   logic [15:0] next_packet_id  = 16'd0;

   mqtt_publish_subscribe_framer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #CLK_HALF clock = ~clock;

   assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

   function automatic logic [47:0] bus_word(input request_t r);
      return {6'd0, r.in_byte, r.qos, r.data_len, r.topic_len};
   endfunction

   function automatic request_t bus_request(input logic [47:0] word,
                                            input logic [1:0] action);
      request_t r;
      r.action    = action;
      r.topic_len = word[15:0];
      r.data_len  = word[31:16];
      r.qos       = word[33:32];
      r.in_byte   = word[41:34];
      return r;
   endfunction

   // ---------------------------------------------------------------- predictor

   function void push_byte(input logic [7:0] value);
      packet_byte_t pb;
      pb.value = value;
      pb.last  = 1'b0;
      packet_bytes_due.push_back(pb);
   endfunction

   function void close_packet();
      packet_byte_t pb;
      pb = packet_bytes_due.pop_back();
      pb.last = 1'b1;
      packet_bytes_due.push_back(pb);
      frame_kind = KIND_IDLE;
   endfunction

   function void push_packet_id();
      push_byte(next_packet_id[15:8]);
      push_byte(next_packet_id[7:0]);
      next_packet_id = next_packet_id + 16'd1;
   endfunction

   function void finish_topic();
      if (frame_kind == KIND_PUB) begin
         if (frame_qos != 2'd0) push_packet_id();
         if (data_remaining == 16'd0) close_packet();
      end else if (frame_kind == KIND_SUB) begin
         push_byte({6'd0, frame_qos});
         close_packet();
      end
   endfunction

   function void frame_request(input request_t r);
      logic [15:0] remaining;
      logic [7:0]  enc;
      case (r.action)
         ACT_START_PUB: begin
            frame_kind      = KIND_PUB;
            frame_qos       = r.qos;
            topic_remaining = r.topic_len;
            data_remaining  = r.data_len;
            // 16-bit sum, wraps like the packet length field
            remaining = 16'd2 + r.topic_len + r.data_len
                        + ((r.qos != 2'd0) ? 16'd2 : 16'd0);
            push_byte(HDR_PUBLISH | {5'd0, r.qos, 1'b0});
            do begin
               enc       = {1'b0, remaining[6:0]};
               remaining = remaining >> 7;
               if (remaining != 16'd0) enc[7] = 1'b1;
               push_byte(enc);
            end while (remaining != 16'd0);
            push_byte(r.topic_len[15:8]);
            push_byte(r.topic_len[7:0]);
            if (topic_remaining == 16'd0) finish_topic();
         end
         ACT_START_SUB: begin
            frame_kind      = KIND_SUB;
            frame_qos       = r.qos;
            topic_remaining = r.topic_len;
            data_remaining  = 16'd0;
            push_byte(HDR_SUBSCRIBE);
            push_byte(r.topic_len[7:0] + SUB_LEN_EXTRA);
            push_packet_id();
            push_byte(r.topic_len[15:8]);
            push_byte(r.topic_len[7:0]);
            if (topic_remaining == 16'd0) finish_topic();
         end
         ACT_BYTE: begin
            if (frame_kind != KIND_IDLE) begin
               if (topic_remaining != 16'd0) begin
                  push_byte(r.in_byte);
                  topic_remaining = topic_remaining - 16'd1;
                  if (topic_remaining == 16'd0) finish_topic();
               end else if (frame_kind == KIND_PUB && data_remaining != 16'd0) begin
                  push_byte(r.in_byte);
                  data_remaining = data_remaining - 16'd1;
                  if (data_remaining == 16'd0) close_packet();
               end else begin
                  frame_kind = KIND_IDLE;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   function void queue_request(input logic [1:0] action, input logic [15:0] tl,
                               input logic [15:0] dl, input logic [1:0] q,
                               input logic [7:0] b);
      request_t r;
      r.action    = action;
      r.topic_len = tl;
      r.data_len  = dl;
      r.qos       = q;
      r.in_byte   = b;
      pending_requests.push_back(r);
   endfunction

   // fields a request does not use carry random values
   function void start_publish(input logic [15:0] tl, input logic [15:0] dl,
                               input logic [1:0] q);
      queue_request(ACT_START_PUB, tl, dl, q, 8'($urandom));
   endfunction

   function void start_subscribe(input logic [15:0] tl, input logic [1:0] q);
      queue_request(ACT_START_SUB, tl, 16'($urandom), q, 8'($urandom));
   endfunction

   function void payload(input logic [7:0] b);
      queue_request(ACT_BYTE, 16'($urandom), 16'($urandom), 2'($urandom), b);
   endfunction

   // ---------------------------------------------------------------- driving

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() != 0 &&
             (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            drive_req = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= bus_word(drive_req);
            req_tuser  <= drive_req.action;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready  <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------- checking

   // prediction first, so a request and its bytes never race within a step
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) frame_request(bus_request(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (packet_bytes_due.size() == 0) begin
               failures = failures + 1;
               if (failures <= MAX_REPORTS)
                  $display("cycle %0d: unexpected byte %02h last %0b",
                           cycle_count, rsp_tdata, rsp_tlast);
            end else begin
               due_byte = packet_bytes_due.pop_front();
               if (rsp_tdata !== due_byte.value || rsp_tlast !== due_byte.last) begin
                  failures = failures + 1;
                  if (failures <= MAX_REPORTS)
                     $display("cycle %0d: expected byte %02h last %0b, got byte %02h last %0b",
                              cycle_count, due_byte.value, due_byte.last,
                              rsp_tdata, rsp_tlast);
               end
            end
         end
      end
   end

   initial begin
      int          counted;
      int          pick;
      int          body;
      logic [15:0] tl;
      logic [15:0] dl;
      logic [1:0]  q;

      // stray requests while idle
      payload(8'hFF);
      queue_request(ACT_NONE, 16'hFFFF, 16'hFFFF, 2'd3, 8'hFF);
      // empty publish at qos 0 ends on the topic length
      start_publish(16'd0, 16'd0, 2'd0);
      // empty topic, id follows the topic length
      start_publish(16'd0, 16'd2, 2'd1);
      payload(8'h00);
      payload(8'hFF);
      // empty subscribe, qos byte follows the topic length
      start_subscribe(16'd0, 2'd3);
      start_publish(16'd2, 16'd1, 2'd3);
      payload(8'hA5);
      payload(8'h5A);
      payload(8'h81);
      start_subscribe(16'd3, 2'd2);
      payload(8'h00);
      payload(8'h7F);
      payload(8'hFF);
      // three-byte remaining length, then abandoned by a new start
      start_publish(16'd16000, 16'd400, 2'd0);
      payload(8'h12);
      payload(8'h34);
      start_publish(16'hFFFF, 16'hFFFF, 2'd2);
      payload(8'h56);
      start_subscribe(16'hFFFF, 2'd1);
      // one-byte remaining length
      start_publish(16'd100, 16'd0, 2'd0);
      payload(8'h01);
      start_publish(16'd1, 16'd0, 2'd1);
      payload(8'hC3);

      counted = pending_requests.size();

      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            q  = 2'($urandom_range(0, 3));
            tl = 16'($urandom_range(0, 6));
            if ($urandom_range(0, 1) == 1) begin
               dl = 16'($urandom_range(0, 8));
               start_publish(tl, dl, q);
               body = int'(tl) + int'(dl);
            end else begin
               start_subscribe(tl, q);
               body = int'(tl);
            end
            // now and then cut short, the next start abandons it
            if ($urandom_range(0, 9) == 0) body = $urandom_range(0, body);
            for (int i = 0; i < body; i++) payload(8'($urandom_range(0, 255)));
            counted += 1 + body;
         end else if (pick < 82) begin
            // full-range lengths, only a few bytes pass before the next start
            tl   = 16'($urandom_range(0, 65535));
            dl   = 16'($urandom_range(0, 65535));
            q    = 2'($urandom_range(0, 3));
            body = $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 1) start_publish(tl, dl, q);
            else start_subscribe(tl, q);
            for (int i = 0; i < body; i++) payload(8'($urandom_range(0, 255)));
            counted += 1 + body;
         end else if (pick < 92) begin
            payload(8'($urandom_range(0, 255)));
            counted += 1;
         end else begin
            queue_request(ACT_NONE, 16'($urandom), 16'($urandom), 2'($urandom),
                          8'($urandom));
            counted += 1;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while ((pending_requests.size() != 0 || req_tvalid || packet_bytes_due.size() != 0)
             && cycle_count < CYCLE_LIMIT)
         @(negedge clock);

      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
      end else begin
         repeat (DRAIN_CYCLES) @(negedge clock);
         if (packet_bytes_due.size() != 0) failures = failures + 1;
         if (failures == 0) begin
            $display("Regression PASS");
         end else begin
            $display("Regression FAIL");
         end
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/mqttfr_pkg.sv
sv/mqtt_publish_subscribe_framer.sv
verif/tb_mqtt_publish_subscribe_framer.sv
